FILE: design/rau_pkg.sv
`default_nettype none
package rau_pkg;
	localparam int WORD_WIDTH = 32;
	localparam int MW = 33;   // operand magnitude width
	localparam int PW = 66;   // product / sum width

	typedef enum logic [2:0] {
		K_ADD = 3'd0, K_SUB = 3'd1, K_MUL = 3'd2, K_DIV = 3'd3,
		K_NEG = 3'd4, K_ABS = 3'd5, K_NRM = 3'd6, K_NRM7 = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_OVF = 2'd2, ST_RSV = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         status;
	} out_word_t;
endpackage
`default_nettype wire

FILE: design/rau_mul.sv
`default_nettype none
// Shift-add multiplier, 33x33 -> 66, one bit of the multiplier per cycle.
module rau_mul import rau_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [MW-1:0] x,
	input  wire logic [MW-1:0] y,
	output logic               done,
	output logic [PW-1:0]      p
);
	logic [PW-1:0] acc_q, mc_q;
	logic [MW-1:0] mp_q;
	logic [5:0]    cnt_q;
	logic          run_q;

	assign p = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			// product is complete on the last multiplier bit
			done <= !start && run_q && (cnt_q == 6'(MW - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				acc_q <= '0;
				mc_q  <= PW'(x);
				mp_q  <= y;
			end else if (run_q) begin
				if (mp_q[0]) acc_q <= acc_q + mc_q;
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(MW - 1)) run_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/rau_gcd.sv
`default_nettype none
// Binary gcd over 66-bit values, then exact division by restoring divide.
// Outputs n/g and d/g. A zero d takes g = n.
module rau_gcd import rau_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [PW-1:0] n,
	input  wire logic [PW-1:0] d,
	output logic               done,
	output logic [PW-1:0]      qn,
	output logic [PW-1:0]      qd
);
	typedef enum logic [2:0] {G_IDLE, G_STRIP, G_LOOP, G_DIVN, G_DIVD} gst_t;
	gst_t          st_q;
	logic [PW-1:0] u_q, v_q, g_q, d_q;
	logic [6:0]    sh_q, bit_q;
	logic [PW-1:0] rem_q, quo_q;
	logic [PW:0]   trial;
	logic [PW-1:0] diff, rem_nxt, quo_nxt;

	// one restoring-divide step by g
	assign trial   = {rem_q, quo_q[PW-1]} - {1'b0, g_q};
	assign rem_nxt = trial[PW] ? {rem_q[PW-2:0], quo_q[PW-1]} : trial[PW-1:0];
	assign quo_nxt = {quo_q[PW-2:0], !trial[PW]};
	assign diff    = (u_q > v_q) ? u_q - v_q : v_q - u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= G_IDLE;
			done <= 1'b0;
		end else begin
			done <= (st_q == G_DIVD) && (bit_q == 7'(PW - 1));
			case (st_q)
				G_IDLE: if (start) begin
					d_q   <= d;
					u_q   <= n;
					v_q   <= d;
					sh_q  <= '0;
					bit_q <= '0;
					rem_q <= '0;
					quo_q <= n;
					if (n == '0) begin
						g_q  <= d;
						st_q <= G_DIVN;
					end else if (d == '0) begin
						g_q  <= n;
						st_q <= G_DIVN;
					end else st_q <= G_STRIP;
				end
				// pull out common factors of two
				G_STRIP: begin
					if (!u_q[0] && !v_q[0]) begin
						u_q  <= u_q >> 1;
						v_q  <= v_q >> 1;
						sh_q <= sh_q + 7'd1;
					end else st_q <= G_LOOP;
				end
				G_LOOP: begin
					if (!u_q[0]) u_q <= u_q >> 1;
					else if (!v_q[0]) v_q <= v_q >> 1;
					else if (u_q == v_q) begin
						g_q  <= u_q << sh_q;
						st_q <= G_DIVN;
					end else if (u_q > v_q) u_q <= diff;
					else v_q <= diff;
				end
				// both divides share the divider datapath
				G_DIVN, G_DIVD: begin
					if (bit_q == 7'(PW - 1)) begin
						bit_q <= '0;
						rem_q <= '0;
						if (st_q == G_DIVN) begin
							qn    <= quo_nxt;
							quo_q <= d_q;
							st_q  <= G_DIVD;
						end else begin
							qd   <= quo_nxt;
							st_q <= G_IDLE;
						end
					end else begin
						bit_q <= bit_q + 7'd1;
						rem_q <= rem_nxt;
						quo_q <= quo_nxt;
					end
				end
				default: st_q <= G_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/rational_arithmetic_unit.sv
`default_nettype none
// Channel   | ports                          | handshake
// ----------+--------------------------------+----------------------------
// request   | start, busy, req (in_word_t)   | taken when start && !busy
// result    | done, rsp (out_word_t)         | one-cycle strobe, no stall
//
// Binary kinds run three multiplies, then combine the partial products and
// start the gcd, run the binary gcd loop and two exact divides, and
// register the result in S_GW before done is strobed from S_FIN.
// Unary kinds skip the multiplies. Entry errors go straight to S_FIN, from
// which done is strobed. busy stays high from acceptance until the done strobe.
// Reset clears the sequencer only; the result cannot be stalled.
module rational_arithmetic_unit import rau_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire in_word_t req,
	output logic      busy,
	output logic      done,
	output out_word_t rsp
);
	typedef enum logic [3:0] {S_IDLE, S_M1, S_M2, S_M3, S_COMB, S_GCD, S_GW, S_FIN} st_t;
	st_t st_q;

	logic [2:0]    kind_q;
	logic [MW-1:0] an_q, ad_q, bn_q, bd_q;
	logic          sa_q, sb_q, rs_q;
	logic [PW-1:0] m1_q, m2_q, rn_q, rd_q;
	logic [1:0]    mstep_q;
	logic          mul_start_q, gcd_start_q;
	logic          mul_done, gcd_done;
	logic          entry_err;

	function automatic logic [MW-1:0] mag(input logic [31:0] v);
		return v[31] ? MW'(33'h1_0000_0000) - MW'(v) : MW'(v);
	endfunction

	logic [MW-1:0] an, ad, bn, bd;
	assign an = mag(req.a_num);
	assign ad = mag(req.a_den);
	assign bn = mag(req.b_num);
	assign bd = mag(req.b_den);

	// zero denominator or division by a zero fraction
	assign entry_err = (ad == '0) || (req.kind <= K_DIV && bd == '0) ||
		(req.kind == K_DIV && bn == '0);

	// shared multiplier
	logic [MW-1:0] mx, my;
	logic [PW-1:0] mp;
	rau_mul u_mul (.clk, .arst_n, .start(mul_start_q), .x(mx), .y(my), .done(mul_done),
		.p(mp));

	// gcd/reduce unit
	logic [PW-1:0] qn, qd;
	rau_gcd u_gcd (.clk, .arst_n, .start(gcd_start_q), .n(rn_q), .d(rd_q), .done(gcd_done),
		.qn(qn), .qd(qd));

	// operand select per multiply step
	always_comb begin
		mx = an_q; my = bd_q;
		case (mstep_q)
			2'd0: begin mx = an_q; my = (kind_q == K_MUL) ? bn_q : bd_q; end
			2'd1: begin mx = (kind_q == K_DIV) ? ad_q : bn_q; my = (kind_q == K_DIV) ? bn_q : ad_q; end
			2'd2: begin mx = ad_q; my = bd_q; end
			default: begin mx = an_q; my = bd_q; end
		endcase
	end

	logic s2;
	assign s2 = (kind_q == K_SUB) ? !sb_q : sb_q;

	logic [WORD_WIDTH:0] lim;
	assign lim = (WORD_WIDTH+1)'(1) << (WORD_WIDTH - 1);

	logic ovf;
	assign ovf = (qd > PW'(lim - 1'b1)) ||
		(qn > (rs_q ? PW'(lim) : PW'(lim - 1'b1)));

	assign busy = (st_q != S_IDLE);

	// products and sums are kept to 64 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			done        <= 1'b0;
			mul_start_q <= 1'b0;
			gcd_start_q <= 1'b0;
			mstep_q     <= '0;
		end else begin
			done        <= (st_q == S_FIN);
			mul_start_q <= (st_q == S_IDLE && start && !entry_err && req.kind <= K_DIV) ||
				((st_q == S_M1 || st_q == S_M2) && mul_done);
			gcd_start_q <= (st_q == S_IDLE && start && !entry_err && req.kind > K_DIV) ||
				(st_q == S_GCD);
			case (st_q)
				S_IDLE: if (start) begin
					kind_q <= req.kind;
					an_q <= an; ad_q <= ad; bn_q <= bn; bd_q <= bd;
					sa_q <= req.a_num[31] != req.a_den[31];
					sb_q <= req.b_num[31] != req.b_den[31];
					mstep_q <= '0;
					if (entry_err) begin
						rsp  <= '{res_num: '0, res_den: 31'd1, status: ST_DIV0};
						st_q <= S_FIN;
					end else if (req.kind <= K_DIV) begin
						st_q <= S_M1;
					end else begin
						rn_q <= PW'(an); rd_q <= PW'(ad);
						rs_q <= (req.kind == K_NEG) ? !(req.a_num[31] != req.a_den[31]) :
							(req.kind == K_ABS) ? 1'b0 : (req.a_num[31] != req.a_den[31]);
						st_q <= S_GW;
					end
				end
				S_M1: if (mul_done) begin
					m1_q <= PW'(mp[63:0]); mstep_q <= 2'd1; st_q <= S_M2;
				end
				S_M2: if (mul_done) begin
					m2_q <= PW'(mp[63:0]); mstep_q <= 2'd2; st_q <= S_M3;
				end
				S_M3: if (mul_done) begin
					rd_q <= PW'(mp[63:0]); st_q <= S_COMB;
				end
				// combine the partial products
				S_COMB: begin
					if (kind_q == K_MUL || kind_q == K_DIV) begin
						rn_q <= m1_q; rs_q <= sa_q != sb_q;
						if (kind_q == K_DIV) rd_q <= m2_q;
					end else if (sa_q == s2) begin
						rn_q <= PW'(64'(m1_q + m2_q)); rs_q <= sa_q;
					end else if (m1_q >= m2_q) begin
						rn_q <= m1_q - m2_q; rs_q <= sa_q;
					end else begin
						rn_q <= m2_q - m1_q; rs_q <= s2;
					end
					st_q <= S_GCD;
				end
				S_GCD: st_q <= S_GW;
				S_GW: if (gcd_done) begin
					if (qn == '0)
						rsp <= '{res_num: '0, res_den: 31'd1, status: ST_OK};
					else if (ovf)
						rsp <= '{res_num: '0, res_den: 31'd1, status: ST_OVF};
					else
						rsp <= '{res_num: rs_q ? 32'(-qn) : 32'(qn), res_den: 31'(qd),
							status: ST_OK};
					st_q <= S_FIN;
				end
				S_FIN: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/rau_checker.sv
`default_nettype none
module rau_checker import rau_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire logic      done,
	input wire out_word_t rsp
);
	// accepted word makes the unit busy
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after accept");
	// done only ends a busy period
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");
	// unit is already free while done is high
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy with done");
	// error results are 0/1
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.res_num == '0 && rsp.res_den == 31'd1)
		else $error("bad error result");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (.clk, .arst_n, .start, .busy, .done, .rsp);
`default_nettype wire

FILE: sim/rational_arithmetic_unit_checker.sv
`default_nettype none
// Watches the request and result channels, predicts each reduced fraction
// and compares it with what the unit returns.
module rational_arithmetic_unit_checker import rau_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      busy,
	input  wire in_word_t  req,
	input  wire logic      done,
	input  wire out_word_t rsp,
	output int             err_count,
	output int             pending,
	output int             words_checked
);
	out_word_t expected_q[$];

	// magnitude and sign of a 32-bit two's complement value
	function automatic logic [63:0] mag_of(input logic [31:0] v, output logic neg);
		neg = v[31];
		return neg ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
	endfunction

	function automatic logic [63:0] gcd_of(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// computes the reduced fraction and status for one request word
	function automatic out_word_t reduce_fraction(input in_word_t w);
		out_word_t r;
		kind_t k;
		logic an_neg, ad_neg, bn_neg, bd_neg, sa, sb, s2, rs, binop;
		logic [63:0] an, ad, bn, bd, m1, m2, rn, rd, g, lim;
		k = kind_t'(w.kind);
		binop = (w.kind <= 3'd3);
		an = mag_of(w.a_num, an_neg);
		ad = mag_of(w.a_den, ad_neg);
		bn = mag_of(w.b_num, bn_neg);
		bd = mag_of(w.b_den, bd_neg);
		sa = an_neg ^ ad_neg;
		sb = bn_neg ^ bd_neg;
		lim = 64'd1 << (WORD_WIDTH - 1);
		r.res_num = '0;
		r.res_den = 31'd1;
		r.status = ST_DIV0;
		if (ad == 0 || (binop && bd == 0)) return r;
		if (k == K_DIV && bn == 0) return r;
		case (k)
			K_ADD, K_SUB: begin
				m1 = an * bd;
				m2 = bn * ad;
				s2 = (k == K_SUB) ? !sb : sb;
				if (sa == s2) begin
					rn = m1 + m2;
					rs = sa;
				end else if (m1 >= m2) begin
					rn = m1 - m2;
					rs = sa;
				end else begin
					rn = m2 - m1;
					rs = s2;
				end
				rd = ad * bd;
			end
			K_MUL: begin
				rn = an * bn;
				rd = ad * bd;
				rs = sa ^ sb;
			end
			K_DIV: begin
				rn = an * bd;
				rd = ad * bn;
				rs = sa ^ sb;
			end
			K_NEG: begin
				rn = an;
				rd = ad;
				rs = !sa;
			end
			K_ABS: begin
				rn = an;
				rd = ad;
				rs = 1'b0;
			end
			default: begin
				rn = an;
				rd = ad;
				rs = sa;
			end
		endcase
		g = gcd_of(rn, rd);
		rn = rn / g;
		rd = rd / g;
		if (rn == 0) begin
			rd = 64'd1;
			rs = 1'b0;
		end
		if (rd > lim - 1 || rn > (rs ? lim : lim - 1)) begin
			r.status = ST_OVF;
			return r;
		end
		r.res_num = rs ? (32'd0 - rn[31:0]) : rn[31:0];
		r.res_den = rd[30:0];
		r.status = ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
		err_count++;
	endtask

	initial begin
		err_count = 0;
		words_checked = 0;
		pending = 0;
	end

	// predict on accept, compare on each result strobe
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected word", rsp.res_num, 32'd0);
				end else begin
					want = expected_q.pop_front();
					words_checked++;
					if (rsp.res_num !== want.res_num)
						report_mismatch("res_num", rsp.res_num, want.res_num);
					if (rsp.res_den !== want.res_den)
						report_mismatch("res_den", 32'(rsp.res_den), 32'(want.res_den));
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
				end
			end
			if (start && !busy) expected_q.push_back(reduce_fraction(req));
			pending = expected_q.size();
		end
	end
endmodule
`default_nettype wire

FILE: sim/rational_arithmetic_unit_tb.sv
`default_nettype none
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_word_t  req = '0;
	logic      busy, done;
	out_word_t rsp;
	int        err_count, pending, words_checked;
	int        kind_seen[8];

	always #5 clk = ~clk;

	rational_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	rational_arithmetic_unit_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .err_count(err_count), .pending(pending),
		.words_checked(words_checked)
	);

	// operand value biased toward edges, small values and full random
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
			4, 5: return $urandom_range(0, 40) - 20;
			6: return $urandom_range(0, 1) ? ($urandom & 32'hffff) : -($urandom & 32'hffff);
			default: return $urandom;
		endcase
	endfunction

	// presents one word and holds it until accepted, then idles for the given gap, if any
	task automatic send_word(input kind_t k, input logic [31:0] an, input logic [31:0] ad,
			input logic [31:0] bn, input logic [31:0] bd, input int gap);
		req <= '{kind: k, a_num: an, a_den: ad, b_num: bn, b_den: bd};
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		kind_seen[k]++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	initial begin
		int den;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: each kind, zero denominators, divide by zero, overflow, signs
		send_word(K_ADD, 1, 2, 1, 3, 0);
		send_word(K_SUB, 5, 1, 1, 3, 0);
		send_word(K_MUL, -6, 4, 2, -3, 0);
		send_word(K_DIV, 3, 4, -9, 8, 0);
		send_word(K_NEG, 32'h8000_0000, 1, 0, 0, 0);
		send_word(K_ABS, 7, -14, 0, 0, 0);
		send_word(K_NRM, -10, -4, 0, 0, 0);
		send_word(K_NRM7, 4, 6, 0, 0, 0);
		send_word(K_ADD, 1, 0, 1, 1, 0);
		send_word(K_MUL, 1, 1, 1, 0, 0);
		send_word(K_NEG, 1, 1, 1, 0, 0);
		send_word(K_DIV, 1, 1, 0, 5, 0);
		send_word(K_ADD, 0, 5, 0, -7, 0);
		send_word(K_ADD, 32'h7fff_ffff, 1, 1, 1, 0);
		send_word(K_SUB, 32'h8000_0000, 1, 1, 1, 0);
		send_word(K_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_word(K_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_word(K_NRM, 32'h8000_0000, -1, 0, 0, 0);
		send_word(K_NRM, 1, 32'h8000_0000, 0, 0, 0);
		send_word(K_ABS, 32'h8000_0000, 1, 0, 0, 0);
		send_word(K_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
		// random
		repeat (1350) begin
			den = $urandom_range(0, 3) == 0 ? pick_value() : $urandom_range(1, 1000);
			send_word(kind_t'($urandom_range(0, 7)), pick_value(), den,
				pick_value(), $urandom_range(0, 3) == 0 ? pick_value() : $urandom_range(1, 1000),
				pick_gap());
		end
		start <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		$display("Checked %0d result words; kinds add/sub/mul/div %0d/%0d/%0d/%0d",
			words_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("neg/abs/norm/norm7 %0d/%0d/%0d/%0d, edges and zero denominators included",
			kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
		if (err_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit: 1371 words at the longest time per word plus the longest gap, several times over
	initial begin
		#60_000_000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
design/rau_pkg.sv
design/rau_mul.sv
design/rau_gcd.sv
design/rational_arithmetic_unit.sv
design/rau_checker.sv
sim/rational_arithmetic_unit_checker.sv
sim/rational_arithmetic_unit_tb.sv
